// ===== rtl/ft_pkg.sv =====
// shared constants, codes and control/status types of the fenwick tree engine
`timescale 1ns / 1ps

package ft_pkg;

    // tree size and derived widths
    localparam int ENTRIES   = 1024;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int K_W       = IDX_W + 2;
    // fixed field widths of the channels
    localparam int CMD_W     = 3;
    localparam int IN_IDX_W  = 11;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 10;
    // width for saturating index arithmetic and for signed bisection bounds
    localparam int W_W       = ((IN_IDX_W > IDX_W + 1) ? IN_IDX_W : IDX_W + 1) + 1;
    localparam int B_W       = W_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 3'd0,
        CMD_SET    = 3'd1,
        CMD_PREFIX = 3'd2,
        CMD_RANGE  = 3'd3,
        CMD_FWD    = 3'd4,
        CMD_BWD    = 3'd5
    } t_cmd;

    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_LOAD      = 4'd1,
        OP_SAVE_BASE = 4'd2,
        OP_DELTA_X   = 4'd3,
        OP_DELTA_SET = 4'd4,
        OP_SUM_ACC   = 4'd5,
        OP_SUM_DIFF  = 4'd6,
        OP_BIS_INIT  = 4'd7,
        OP_BIS_STEP  = 4'd8,
        OP_BIS_END   = 4'd9,
        OP_OUT_LOAD  = 4'd10
    } t_dp_op;

    // start index of a tree walk
    typedef enum logic [2:0] {
        K_A1  = 3'd0,
        K_A   = 3'd1,
        K_B   = 3'd2,
        K_R1  = 3'd3,
        K_MID = 3'd4
    } t_ksel;

    typedef struct packed {
        t_dp_op op;
        logic   walk_start;
        logic   walk_upd;
        t_ksel  ksel;
        logic   clr_step;
    } t_dp_ctrl;

    typedef struct packed {
        t_cmd cmd;
        logic idx_ok;
        logic walk_done;
        logic bis_more;
        logic clr_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/ft_if.sv =====
// valid/ready channel interfaces for command and result words
`timescale 1ns / 1ps

interface ft_in_if import ft_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [IN_IDX_W-1:0]      index_a;
    logic [IN_IDX_W-1:0]      index_b;
    logic signed [DATA_W-1:0] operand;

    modport source (output valid, output cmd, output index_a, output index_b,
                    output operand, input ready);
    modport sink   (input valid, input cmd, input index_a, input index_b,
                    input operand, output ready);
endinterface

interface ft_out_if import ft_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sum_out;
    logic [POS_W-1:0]         position;
    logic                     found;

    modport source (output valid, output sum_out, output position, output found,
                    input ready);
    modport sink   (input valid, input sum_out, input position, input found,
                    output ready);
endinterface

// ===== rtl/ft_ctrl.sv =====
// sequencing state machine of the fenwick tree engine
`timescale 1ns / 1ps

module ft_ctrl import ft_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_ctrl o_ctrl
);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_DISP  = 9'b000000100,
        S_WALK1 = 9'b000001000,
        S_WALK2 = 9'b000010000,
        S_UPD   = 9'b000100000,
        S_BCHK  = 9'b001000000,
        S_BWALK = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state           = r_state;
        o_ctrl.op         = OP_NONE;
        o_ctrl.walk_start = 1'b0;
        o_ctrl.walk_upd   = 1'b0;
        o_ctrl.ksel       = K_A1;
        o_ctrl.clr_step   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_ctrl.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.op = OP_LOAD;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.cmd)
                    CMD_ADD: begin
                        if (i_stat.idx_ok) begin
                            o_ctrl.op         = OP_DELTA_X;
                            o_ctrl.walk_start = 1'b1;
                            o_ctrl.walk_upd   = 1'b1;
                            o_ctrl.ksel       = K_A1;
                            n_state           = S_UPD;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    CMD_SET: begin
                        if (i_stat.idx_ok) begin
                            o_ctrl.walk_start = 1'b1;
                            o_ctrl.ksel       = K_A1;
                            n_state           = S_WALK1;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    CMD_PREFIX: begin
                        o_ctrl.walk_start = 1'b1;
                        o_ctrl.ksel       = K_A1;
                        n_state           = S_WALK1;
                    end
                    CMD_RANGE: begin
                        o_ctrl.walk_start = 1'b1;
                        o_ctrl.ksel       = K_B;
                        n_state           = S_WALK1;
                    end
                    CMD_FWD: begin
                        o_ctrl.walk_start = 1'b1;
                        o_ctrl.ksel       = K_A;
                        n_state           = S_WALK1;
                    end
                    CMD_BWD: begin
                        o_ctrl.walk_start = 1'b1;
                        o_ctrl.ksel       = K_R1;
                        n_state           = S_WALK1;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_WALK1: begin
                if (i_stat.walk_done) begin
                    case (i_stat.cmd)
                        CMD_SET, CMD_RANGE: begin
                            o_ctrl.op         = OP_SAVE_BASE;
                            o_ctrl.walk_start = 1'b1;
                            o_ctrl.ksel       = K_A;
                            n_state           = S_WALK2;
                        end
                        CMD_PREFIX: begin
                            o_ctrl.op = OP_SUM_ACC;
                            n_state   = S_DONE;
                        end
                        CMD_FWD, CMD_BWD: begin
                            o_ctrl.op = OP_BIS_INIT;
                            n_state   = S_BCHK;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_WALK2: begin
                if (i_stat.walk_done) begin
                    if (i_stat.cmd == CMD_SET) begin
                        o_ctrl.op         = OP_DELTA_SET;
                        o_ctrl.walk_start = 1'b1;
                        o_ctrl.walk_upd   = 1'b1;
                        o_ctrl.ksel       = K_A1;
                        n_state           = S_UPD;
                    end else begin
                        o_ctrl.op = OP_SUM_DIFF;
                        n_state   = S_DONE;
                    end
                end
            end
            S_UPD: begin
                if (i_stat.walk_done) begin
                    n_state = S_DONE;
                end
            end
            S_BCHK: begin
                if (i_stat.bis_more) begin
                    o_ctrl.walk_start = 1'b1;
                    o_ctrl.ksel       = K_MID;
                    n_state           = S_BWALK;
                end else begin
                    o_ctrl.op = OP_BIS_END;
                    n_state   = S_DONE;
                end
            end
            S_BWALK: begin
                if (i_stat.walk_done) begin
                    o_ctrl.op = OP_BIS_STEP;
                    n_state   = S_BCHK;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_ctrl.op = OP_OUT_LOAD;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/ft_dp.sv =====
// tree memory, walk unit, bisection registers and result register
`timescale 1ns / 1ps

module ft_dp import ft_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_ctrl                 i_ctrl,
    output t_dp_stat                 o_stat,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic [IN_IDX_W-1:0]      i_index_a,
    input  logic [IN_IDX_W-1:0]      i_index_b,
    input  logic signed [DATA_W-1:0] i_operand,
    ft_out_if.source                 o_out
);

    logic [DATA_W-1:0] mem [ENTRIES];

    logic [CMD_W-1:0]    r_cmd;
    logic [IN_IDX_W-1:0] r_a;
    logic [IN_IDX_W-1:0] r_b;
    logic [DATA_W-1:0]   r_x;
    logic [DATA_W-1:0]   r_acc;
    logic [DATA_W-1:0]   r_base;
    logic [DATA_W-1:0]   r_delta;
    logic [K_W-1:0]      r_k;
    logic                r_run;
    logic                r_pend;
    logic                r_upd;
    logic [IDX_W-1:0]    r_waddr;
    logic [DATA_W-1:0]   r_rdata;
    logic signed [B_W-1:0] r_lo;
    logic signed [B_W-1:0] r_hi;
    logic signed [B_W-1:0] r_mid;
    logic [DATA_W-1:0]   r_sum;
    logic [POS_W-1:0]    r_pos;
    logic                r_found;
    logic                r_ovalid;
    logic [DATA_W-1:0]   r_osum;
    logic [POS_W-1:0]    r_opos;
    logic                r_ofound;
    logic [IDX_W-1:0]    r_clr_addr;

    function automatic logic [W_W-1:0] sat_k(input logic [W_W-1:0] v);
        return (v > W_W'(ENTRIES)) ? W_W'(ENTRIES) : v;
    endfunction

    logic [W_W-1:0]        a_w;
    logic [W_W-1:0]        b_w;
    logic [W_W-1:0]        rsat_w;
    logic [K_W-1:0]        rsat1_k;
    logic signed [B_W-1:0] lm1;
    logic signed [B_W-1:0] rsat1_s;
    logic signed [B_W:0]   mid_sum;
    logic signed [B_W-1:0] mid;
    logic                  is_fwd;
    logic [K_W-1:0]        k_start;
    logic [K_W-1:0]        lowbit;
    logic                  issue_ok;
    logic [IDX_W-1:0]      rd_addr;
    logic [DATA_W-1:0]     diff;
    logic                  reach;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [DATA_W-1:0]     mem_wdata;

    assign a_w     = W_W'(r_a);
    assign b_w     = W_W'(r_b);
    assign rsat_w  = (b_w > W_W'(ENTRIES - 1)) ? W_W'(ENTRIES - 1) : b_w;
    assign rsat1_k = K_W'(rsat_w + W_W'(1));
    assign lm1     = $signed({1'b0, a_w}) - B_W'(1);
    assign rsat1_s = $signed({1'b0, rsat_w}) + B_W'(1);
    assign mid_sum = (B_W+1)'(r_lo) + (B_W+1)'(r_hi);
    assign mid     = B_W'(mid_sum >>> 1);
    assign is_fwd  = (r_cmd == CMD_FWD);

    always_comb begin
        case (i_ctrl.ksel)
            K_A1:    k_start = K_W'(sat_k(a_w + W_W'(1)));
            K_A:     k_start = K_W'(sat_k(a_w));
            K_B:     k_start = K_W'(sat_k(b_w));
            K_R1:    k_start = rsat1_k;
            K_MID:   k_start = is_fwd ? K_W'(mid + B_W'(1)) : K_W'(mid);
            default: k_start = '0;
        endcase
    end

    // walk: read mode strips the low bit, update mode climbs by it
    assign lowbit   = r_k & (~r_k + K_W'(1));
    assign issue_ok = r_upd ? (r_k <= K_W'(ENTRIES)) : (r_k != '0);
    assign rd_addr  = IDX_W'(r_k - K_W'(1));

    assign diff  = is_fwd ? (r_acc - r_base) : (r_base - r_acc);
    assign reach = ($signed(diff) >= $signed(r_x));

    assign mem_we    = i_ctrl.clr_step || (r_pend && r_upd);
    assign mem_waddr = i_ctrl.clr_step ? r_clr_addr : r_waddr;
    assign mem_wdata = i_ctrl.clr_step ? '0 : (r_rdata + r_delta);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run      <= 1'b0;
            r_pend     <= 1'b0;
            r_ovalid   <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            if (i_ctrl.clr_step) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (i_ctrl.walk_start) begin
                r_run  <= 1'b1;
                r_pend <= 1'b0;
            end else if (r_run && issue_ok) begin
                r_pend <= 1'b1;
            end else begin
                r_run  <= 1'b0;
                r_pend <= 1'b0;
            end
            if (i_ctrl.op == OP_OUT_LOAD) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.walk_start) begin
            r_k   <= k_start;
            r_upd <= i_ctrl.walk_upd;
            r_acc <= '0;
            r_mid <= mid;
        end else begin
            if (r_run && issue_ok) begin
                r_waddr <= rd_addr;
                r_k     <= r_upd ? (r_k + lowbit) : (r_k - lowbit);
            end
            if (r_pend && !r_upd) begin
                r_acc <= r_acc + r_rdata;
            end
        end

        case (i_ctrl.op)
            OP_LOAD: begin
                r_cmd   <= i_cmd;
                r_a     <= i_index_a;
                r_b     <= i_index_b;
                r_x     <= i_operand;
                r_sum   <= '0;
                r_pos   <= '0;
                r_found <= 1'b0;
            end
            OP_SAVE_BASE: begin
                r_base <= r_acc;
            end
            OP_DELTA_X: begin
                r_delta <= r_x;
            end
            OP_DELTA_SET: begin
                r_delta <= r_x - (r_base - r_acc);
            end
            OP_SUM_ACC: begin
                r_sum <= r_acc;
            end
            OP_SUM_DIFF: begin
                r_sum <= r_base - r_acc;
            end
            OP_BIS_INIT: begin
                r_base <= r_acc;
                r_lo   <= lm1;
                r_hi   <= rsat1_s;
            end
            OP_BIS_STEP: begin
                if (reach == is_fwd) begin
                    r_hi <= r_mid;
                end else begin
                    r_lo <= r_mid;
                end
            end
            OP_BIS_END: begin
                if (is_fwd) begin
                    r_found <= (r_hi != rsat1_s);
                    r_pos   <= (r_hi != rsat1_s) ? POS_W'(r_hi) : '0;
                end else begin
                    r_found <= (r_lo != lm1);
                    r_pos   <= (r_lo != lm1) ? POS_W'(r_lo) : '0;
                end
            end
            OP_OUT_LOAD: begin
                r_osum   <= r_sum;
                r_opos   <= r_pos;
                r_ofound <= r_found;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.cmd       = t_cmd'(r_cmd);
    assign o_stat.idx_ok    = (a_w < W_W'(ENTRIES));
    assign o_stat.walk_done = !r_run && !r_pend;
    assign o_stat.bis_more  = ((r_lo + B_W'(1)) < r_hi);
    assign o_stat.clr_last  = (r_clr_addr == IDX_W'(ENTRIES - 1));
    assign o_stat.out_free  = !r_ovalid || o_out.ready;

    assign o_out.valid    = r_ovalid;
    assign o_out.sum_out  = r_osum;
    assign o_out.position = r_opos;
    assign o_out.found    = r_ofound;

endmodule

// ===== rtl/fenwick_tree_engine.sv =====
// fenwick tree engine: binary indexed tree with sum, update and search commands
// a tree walk makes one memory access per cycle
// add: one update walk; set: two read walks then an update walk; prefix sum: one read walk; range sum: two read walks
// searches: a read walk, then a bisection loop with one read walk per bisection step
// one word at a time; the next command is taken while a result waits, a full one stalls done
// after reset a clearing pass zeroes the tree before any command
`timescale 1ns / 1ps

module fenwick_tree_engine import ft_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ft_in_if.sink    i_in,
    ft_out_if.source o_out
);

    // controller/datapath hookup
    t_dp_ctrl ctrl;
    t_dp_stat stat;
    logic     in_ready;

    assign i_in.ready = in_ready;

    // sequencing: clear pass, dispatch, walks, bisection loop, result hand-off
    ft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    // tree memory and the walk/bisection arithmetic, plus the output register
    ft_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .o_stat    (stat),
        .i_cmd     (i_in.cmd),
        .i_index_a (i_in.index_a),
        .i_index_b (i_in.index_b),
        .i_operand (i_in.operand),
        .o_out     (o_out)
    );

    // a walk never starts over one still in flight
    a_walk_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.walk_start |-> stat.walk_done)
        else $error("walk started while previous walk busy");

    // a result only appears after the controller loads it
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(ctrl.op == OP_OUT_LOAD))
        else $error("result valid without a load");

    // one word at a time: ready drops after each accepted word
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second word taken while busy");

    // a miss reports position zero
    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |-> (o_out.position == '0))
        else $error("nonzero position without a hit");

endmodule
